// ===== hw/rtl/qrb_pkg.sv =====
// Shared types and constants of the quaternion rate to body rate unit.
package qrb_pkg;

    localparam int LANES      = 4;
    localparam int LANE_W     = 16;
    localparam int RATE_W     = 24;
    localparam int TIME_W     = 32;
    localparam int QUAT_W     = LANES * LANE_W;
    // squared lane, sum of squares, norm search accumulators
    localparam int SQ_W       = 31;
    localparam int SUM_W      = 33;
    localparam int ACC_W      = 70;
    localparam int TGT_SHIFT  = 30;
    // unit lane magnitude range is 0..16384, one result bit per search stage
    localparam int MAG_W      = 15;
    localparam int NORM_STEPS = MAG_W;
    // input register, norm sum, then one stage per magnitude bit
    localparam int NORM_STAGES = 2 + NORM_STEPS;
    localparam int PROD_W     = LANE_W + RATE_W;
    localparam int RSUM_W     = PROD_W + 2;
    localparam int RND_BIAS   = 4096;
    localparam int RND_SHIFT  = 13;
    localparam int RATE_MAX   = 8388607;
    localparam int RATE_MIN   = -8388608;

    // register indexes of the configuration port
    localparam logic REG_FINAL_TIME = 1'b0;

    typedef logic signed [RATE_W-1:0] rate_t;

    // what travels with a transaction through the normalization and sign stages
    typedef struct packed {
        logic [QUAT_W-1:0]   raw;
        rate_t [LANES-1:0]   dq;
        rate_t [LANES-1:0]   ddq;
        logic                past;
    } payload_t;

    // state of one normalization stage
    typedef struct packed {
        payload_t                     p;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][SQ_W-1:0]   sq;
        logic [SUM_W-1:0]             s;
        logic [LANES-1:0][MAG_W-1:0]  a;
        logic [LANES-1:0][ACC_W-1:0]  q2;
        logic [LANES-1:0][ACC_W-1:0]  r1;
    } nstage_t;

endpackage

// ===== hw/rtl/qrb_norm.sv =====
// Quaternion normalization pipeline: squares, norm sum, bitwise magnitude search.
module qrb_norm (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  qrb_pkg::payload_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output qrb_pkg::nstage_t              out_data
);

    localparam int NS = qrb_pkg::NORM_STAGES;

    logic                 v_reg  [NS];
    qrb_pkg::nstage_t     d_reg  [NS];
    qrb_pkg::nstage_t     d_next [NS];
    logic [NS:0]          en;

    // stall chain: a stage moves when empty or when the next one moves
    assign en[NS] = out_ready;
    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++) begin : g_en
            assign en[gi] = !v_reg[gi] || en[gi+1];
        end
    endgenerate
    assign in_ready = en[0];

    // input stage: lane squares and signs
    always_comb begin
        logic signed [qrb_pkg::LANE_W-1:0]   ql;
        logic signed [2*qrb_pkg::LANE_W-1:0] qq;
        d_next[0]   = '0;
        d_next[0].p = in_data;
        for (int l = 0; l < qrb_pkg::LANES; l++) begin
            ql = in_data.raw[l*qrb_pkg::LANE_W +: qrb_pkg::LANE_W];
            qq = ql * ql;
            d_next[0].neg[l] = ql[qrb_pkg::LANE_W-1];
            d_next[0].sq[l]  = qq[qrb_pkg::SQ_W-1:0];
        end
    end

    // sum of squares
    always_comb begin
        d_next[1]   = d_reg[0];
        d_next[1].s = '0;
        for (int l = 0; l < qrb_pkg::LANES; l++) begin
            d_next[1].s = d_next[1].s + qrb_pkg::SUM_W'(d_reg[0].sq[l]);
        end
    end

    // magnitude search: stage for bit k keeps a*a*S and a*S of the running result
    generate
        for (gi = 2; gi < NS; gi++) begin : g_step
            localparam int K = NS - 1 - gi;
            always_comb begin
                logic [qrb_pkg::ACC_W-1:0] sx;
                logic [qrb_pkg::ACC_W-1:0] cs;
                logic [qrb_pkg::ACC_W-1:0] c2s;
                logic [qrb_pkg::ACC_W-1:0] test;
                logic [qrb_pkg::ACC_W-1:0] tgt;
                d_next[gi] = d_reg[gi-1];
                sx = qrb_pkg::ACC_W'(d_reg[gi-1].s);
                for (int l = 0; l < qrb_pkg::LANES; l++) begin
                    cs   = d_reg[gi-1].r1[l] + (sx << K);
                    c2s  = d_reg[gi-1].q2[l] + (d_reg[gi-1].r1[l] << (K + 1)) + (sx << (2 * K));
                    test = (c2s << 2) - (cs << 2) + sx;
                    tgt  = qrb_pkg::ACC_W'(d_reg[gi-1].sq[l]) << qrb_pkg::TGT_SHIFT;
                    if (test <= tgt) begin
                        d_next[gi].a[l]  = d_reg[gi-1].a[l] | qrb_pkg::MAG_W'(1 << K);
                        d_next[gi].q2[l] = c2s;
                        d_next[gi].r1[l] = cs;
                    end
                end
            end
        end
    endgenerate

    // stage registers
    generate
        for (gi = 0; gi < NS; gi++) begin : g_reg
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[gi] <= 1'b0;
                end else if (en[gi]) begin
                    v_reg[gi] <= (gi == 0) ? in_valid : v_reg[(gi == 0) ? 0 : gi-1];
                end
            end
            always_ff @(posedge aclk) begin
                if (en[gi]) begin
                    d_reg[gi] <= d_next[gi];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NS-1];
    assign out_data  = d_reg[NS-1];

endmodule

// ===== hw/rtl/qrb_rate.sv =====
// Signed unit quaternion, rate products, rounding and saturation to the output register.
module qrb_rate (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  qrb_pkg::nstage_t            in_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [qrb_pkg::QUAT_W-1:0]  orient,
    output qrb_pkg::rate_t [2:0]        omega,
    output qrb_pkg::rate_t [2:0]        alpha
);

    typedef logic signed [qrb_pkg::LANE_W-1:0] lane_t;
    typedef logic signed [qrb_pkg::PROD_W-1:0] prod_t;

    typedef struct packed {
        qrb_pkg::payload_t              p;
        lane_t [qrb_pkg::LANES-1:0]     n;
    } ustage_t;

    typedef struct packed {
        logic                           past;
        logic [qrb_pkg::QUAT_W-1:0]     orient;
        prod_t [1:0][2:0][3:0]          pr;
    } pstage_t;

    logic     va_reg, vb_reg, vc_reg;
    logic     ena, enb, enc;
    ustage_t  a_reg, a_next;
    pstage_t  b_reg, b_next;
    logic [qrb_pkg::QUAT_W-1:0] orient_reg, orient_next;
    qrb_pkg::rate_t [1:0][2:0]  rate_reg, rate_next;

    assign enc      = !vc_reg || m_ready;
    assign enb      = !vb_reg || enc;
    assign ena      = !va_reg || enb;
    assign in_ready = ena;

    // apply sign, zero norm gives zero lanes
    always_comb begin
        a_next.p = in_data.p;
        for (int l = 0; l < qrb_pkg::LANES; l++) begin
            if (in_data.s == '0) begin
                a_next.n[l] = '0;
            end else if (in_data.neg[l]) begin
                a_next.n[l] = -lane_t'({1'b0, in_data.a[l]});
            end else begin
                a_next.n[l] = lane_t'({1'b0, in_data.a[l]});
            end
        end
    end

    // products w*d_i, dw*n_i, n_j*d_k, n_k*d_j per axis
    always_comb begin
        qrb_pkg::rate_t [qrb_pkg::LANES-1:0] d;
        int j;
        int k;
        b_next.past = a_reg.p.past;
        b_next.orient = a_reg.p.raw;
        if (!a_reg.p.past) begin
            for (int l = 0; l < qrb_pkg::LANES; l++) begin
                b_next.orient[l*qrb_pkg::LANE_W +: qrb_pkg::LANE_W] = a_reg.n[l];
            end
        end
        for (int g = 0; g < 2; g++) begin
            d = (g == 0) ? a_reg.p.dq : a_reg.p.ddq;
            for (int i = 0; i < 3; i++) begin
                j = (i + 1) % 3;
                k = (i + 2) % 3;
                b_next.pr[g][i][0] = prod_t'(a_reg.n[3]) * prod_t'(d[i]);
                b_next.pr[g][i][1] = prod_t'(d[3]) * prod_t'(a_reg.n[i]);
                b_next.pr[g][i][2] = prod_t'(a_reg.n[j]) * prod_t'(d[k]);
                b_next.pr[g][i][3] = prod_t'(a_reg.n[k]) * prod_t'(d[j]);
            end
        end
    end

    // doubled sum rounded to Q8.16 and saturated, zero past the end time
    always_comb begin
        logic signed [qrb_pkg::RSUM_W-1:0] sum;
        logic signed [qrb_pkg::RSUM_W-1:0] r;
        orient_next = b_reg.orient;
        for (int g = 0; g < 2; g++) begin
            for (int i = 0; i < 3; i++) begin
                sum = qrb_pkg::RSUM_W'(b_reg.pr[g][i][0]) - qrb_pkg::RSUM_W'(b_reg.pr[g][i][1])
                    - qrb_pkg::RSUM_W'(b_reg.pr[g][i][2]) + qrb_pkg::RSUM_W'(b_reg.pr[g][i][3]);
                r = (sum + qrb_pkg::RSUM_W'(qrb_pkg::RND_BIAS)) >>> qrb_pkg::RND_SHIFT;
                if (b_reg.past) begin
                    rate_next[g][i] = '0;
                end else if (r > qrb_pkg::RSUM_W'(qrb_pkg::RATE_MAX)) begin
                    rate_next[g][i] = qrb_pkg::RATE_W'(qrb_pkg::RATE_MAX);
                end else if (r < qrb_pkg::RSUM_W'(qrb_pkg::RATE_MIN)) begin
                    rate_next[g][i] = qrb_pkg::RATE_W'(qrb_pkg::RATE_MIN);
                end else begin
                    rate_next[g][i] = r[qrb_pkg::RATE_W-1:0];
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (ena) va_reg <= in_valid;
            if (enb) vb_reg <= va_reg;
            if (enc) vc_reg <= vb_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ena) a_reg <= a_next;
        if (enb) b_reg <= b_next;
        if (enc) begin
            orient_reg <= orient_next;
            rate_reg   <= rate_next;
        end
    end

    assign m_valid = vc_reg;
    assign orient  = orient_reg;
    assign omega   = rate_reg[0];
    assign alpha   = rate_reg[1];

endmodule

// ===== hw/rtl/quat_rates_to_body_angular_rates_unit.sv =====
// Top level of the quaternion rate to body angular rate unit.
// Takes one orientation sample per cycle while the output is not stalled and returns one
// result for each, in order, after twenty register stages. The depth is set by the
// fifteen-stage bitwise search for the normalized lane magnitudes, one bit per stage, plus
// input, norm-sum, sign, product and rounding stages. A stalled output holds the pipeline,
// and empty stages still fill while it waits. final_time sits at addresses 0 to 3 of the
// APB port (only paddr[2] is decoded) and reads back; past it the raw quaternion and zero
// rates are returned.
module quat_rates_to_body_angular_rates_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [63:0]         s_orient_raw,
    input  logic signed [23:0]  s_dq_x,
    input  logic signed [23:0]  s_dq_y,
    input  logic signed [23:0]  s_dq_z,
    input  logic signed [23:0]  s_dq_w,
    input  logic signed [23:0]  s_ddq_x,
    input  logic signed [23:0]  s_ddq_y,
    input  logic signed [23:0]  s_ddq_z,
    input  logic signed [23:0]  s_ddq_w,
    input  logic [31:0]         s_now_time,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [63:0]         m_orient_out,
    output logic signed [23:0]  m_omega_x,
    output logic signed [23:0]  m_omega_y,
    output logic signed [23:0]  m_omega_z,
    output logic signed [23:0]  m_alpha_x,
    output logic signed [23:0]  m_alpha_y,
    output logic signed [23:0]  m_alpha_z
);

    logic [qrb_pkg::TIME_W-1:0] final_time_reg;
    logic                       cfg_wr;
    qrb_pkg::payload_t          in_pl;
    logic                       nv;
    logic                       nr;
    qrb_pkg::nstage_t           nd;
    qrb_pkg::rate_t [2:0]       omega;
    qrb_pkg::rate_t [2:0]       alpha;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == qrb_pkg::REG_FINAL_TIME);
    assign prdata = (paddr[2] == qrb_pkg::REG_FINAL_TIME) ? final_time_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            final_time_reg <= '0;
        end else if (cfg_wr) begin
            final_time_reg <= pwdata;
        end
    end

    // input transaction
    always_comb begin
        in_pl.raw    = s_orient_raw;
        in_pl.dq     = {s_dq_w, s_dq_z, s_dq_y, s_dq_x};
        in_pl.ddq    = {s_ddq_w, s_ddq_z, s_ddq_y, s_ddq_x};
        in_pl.past   = s_now_time > final_time_reg;
    end

    qrb_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (in_pl),
        .out_valid (nv),
        .out_ready (nr),
        .out_data  (nd)
    );

    qrb_rate u_rate (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (nv),
        .in_ready (nr),
        .in_data  (nd),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .orient   (m_orient_out),
        .omega    (omega),
        .alpha    (alpha)
    );

    assign m_omega_x = omega[0];
    assign m_omega_y = omega[1];
    assign m_omega_z = omega[2];
    assign m_alpha_x = alpha[0];
    assign m_alpha_y = alpha[1];
    assign m_alpha_z = alpha[2];

`ifndef NO_ASSERTIONS
    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");
    // a free output never blocks the input
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn) m_ready |-> s_ready)
        else $error("input stalled with output ready");
    // register write lands
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> final_time_reg == $past(pwdata))
        else $error("final_time write lost");
`endif

endmodule

// ===== sim/quat_rates_to_body_angular_rates_unit_tb.sv =====
// Testbench for the quaternion rate to body angular rate unit.
`timescale 1ns / 1ps

module quat_rates_to_body_angular_rates_unit_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] ADDR_FINAL_TIME = {qrb_pkg::REG_FINAL_TIME, 2'b00};

    // one sample going in and one result coming out
    typedef struct packed {
        logic [63:0] raw;
        logic signed [23:0] dx, dy, dz, dw;
        logic signed [23:0] ax, ay, az, aw;
        logic [31:0] now;
    } sample_t;

    typedef struct packed {
        logic [63:0] orient;
        logic signed [23:0] wx, wy, wz, ax, ay, az;
    } body_rates_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [63:0] s_orient_raw = '0;
    logic signed [23:0] s_dq_x = '0, s_dq_y = '0, s_dq_z = '0, s_dq_w = '0;
    logic signed [23:0] s_ddq_x = '0, s_ddq_y = '0, s_ddq_z = '0, s_ddq_w = '0;
    logic [31:0] s_now_time = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [63:0] m_orient_out;
    logic signed [23:0] m_omega_x, m_omega_y, m_omega_z;
    logic signed [23:0] m_alpha_x, m_alpha_y, m_alpha_z;

    quat_rates_to_body_angular_rates_unit dut (.*);

    always #5 aclk = ~aclk;

    logic [31:0] final_time_shadow = '0;
    body_rates_t expected_rates[$];
    int errors = 0;
    int sent = 0, received = 0, past_end_count = 0, zero_quat_count = 0;
    int cycles = 0;
    bit hold_off = 1'b0;

    // nearest-integer unit lane magnitude, ties up, exact search
    function automatic longint unsigned unit_lane(longint unsigned mag, longint unsigned s);
        logic [127:0] target, t, prod;
        longint unsigned lo, hi, mid;
        target = 128'(mag * mag) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 128'(2 * mid - 1);
            prod = t * t * 128'(s);
            if (prod <= target) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // doubled Q.30 sum to saturated Q8.16
    function automatic logic signed [23:0] round_rate(longint sum);
        longint r;
        r = (sum + 4096) >>> 13;
        if (r > qrb_pkg::RATE_MAX) r = qrb_pkg::RATE_MAX;
        if (r < qrb_pkg::RATE_MIN) r = qrb_pkg::RATE_MIN;
        return r[23:0];
    endfunction

    function automatic body_rates_t predict_rates(sample_t in);
        body_rates_t o;
        longint q[4], n[4], d[4], e[4];
        longint unsigned s, mag;
        s = 0;
        o = '0;
        if (in.now > final_time_shadow) begin
            o.orient = in.raw;
            return o;
        end
        for (int i = 0; i < 4; i++) begin
            q[i] = longint'($signed(in.raw[16*i +: 16]));
            s += longint'(q[i] * q[i]);
        end
        d = '{longint'(in.dx), longint'(in.dy), longint'(in.dz), longint'(in.dw)};
        e = '{longint'(in.ax), longint'(in.ay), longint'(in.az), longint'(in.aw)};
        for (int i = 0; i < 4; i++) begin
            if (s == 0) n[i] = 0;
            else begin
                mag = q[i] < 0 ? -q[i] : q[i];
                n[i] = q[i] < 0 ? -longint'(unit_lane(mag, s)) : longint'(unit_lane(mag, s));
            end
            o.orient[16*i +: 16] = n[i][15:0];
        end
        o.wx = round_rate(n[3]*d[0] - d[3]*n[0] - (n[1]*d[2] - n[2]*d[1]));
        o.wy = round_rate(n[3]*d[1] - d[3]*n[1] - (n[2]*d[0] - n[0]*d[2]));
        o.wz = round_rate(n[3]*d[2] - d[3]*n[2] - (n[0]*d[1] - n[1]*d[0]));
        o.ax = round_rate(n[3]*e[0] - e[3]*n[0] - (n[1]*e[2] - n[2]*e[1]));
        o.ay = round_rate(n[3]*e[1] - e[3]*n[1] - (n[2]*e[0] - n[0]*e[2]));
        o.az = round_rate(n[3]*e[2] - e[3]*n[2] - (n[0]*e[1] - n[1]*e[0]));
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, received);
    endtask

    // sends one sample after a random gap; valid stays up until the gap of the next one
    task automatic send_sample(sample_t in, bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_orient_raw <= in.raw;
        s_dq_x <= in.dx; s_dq_y <= in.dy; s_dq_z <= in.dz; s_dq_w <= in.dw;
        s_ddq_x <= in.ax; s_ddq_y <= in.ay; s_ddq_z <= in.az; s_ddq_w <= in.aw;
        s_now_time <= in.now;
        do @(posedge aclk); while (!s_ready);
        expected_rates.push_back(predict_rates(in));
        if (in.now > final_time_shadow) past_end_count++;
        else if (in.raw == '0) zero_quat_count++;
        sent++;
    endtask

    task automatic write_final_time(logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_FINAL_TIME; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        final_time_shadow = value;
        @(posedge aclk);
        if (prdata !== value) report_mismatch("final_time readback", prdata, value);
    endtask

    // drops valid and waits until every result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_rates.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    function automatic logic signed [23:0] rand_rate();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($signed($urandom_range(0, 131072)) - 65536);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_lane();
        case ($urandom_range(0, 6))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h4000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic sample_t rand_sample(bit near_end);
        sample_t in;
        in.raw = {rand_lane(), rand_lane(), rand_lane(), rand_lane()};
        if ($urandom_range(0, 19) == 0) in.raw = '0;
        in.dx = rand_rate(); in.dy = rand_rate(); in.dz = rand_rate(); in.dw = rand_rate();
        in.ax = rand_rate(); in.ay = rand_rate(); in.az = rand_rate(); in.aw = rand_rate();
        if (near_end && $urandom_range(0, 3) != 0)
            in.now = final_time_shadow + 32'($urandom_range(0, 2)) - 32'd1;
        else in.now = $urandom;
        return in;
    endfunction

    // result checker with random stalls
    always @(posedge aclk) begin
        body_rates_t want;
        if (aresetn && m_valid && m_ready) begin
            received++;
            if (expected_rates.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_rates.pop_front();
                if (m_orient_out !== want.orient)
                    report_mismatch("orient_out", m_orient_out, want.orient);
                if (m_omega_x !== want.wx) report_mismatch("omega_x", m_omega_x, want.wx);
                if (m_omega_y !== want.wy) report_mismatch("omega_y", m_omega_y, want.wy);
                if (m_omega_z !== want.wz) report_mismatch("omega_z", m_omega_z, want.wz);
                if (m_alpha_x !== want.ax) report_mismatch("alpha_x", m_alpha_x, want.ax);
                if (m_alpha_y !== want.ay) report_mismatch("alpha_y", m_alpha_y, want.ay);
                if (m_alpha_z !== want.az) report_mismatch("alpha_z", m_alpha_z, want.az);
            end
        end
    end

    // receiver: per-transaction random wait, or a long hold-off
    initial begin
        int wait_cycles;
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (120) @(posedge aclk);
                hold_off = 1'b0;
            end
            wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
            if (wait_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed();
        sample_t in;
        logic [15:0] lanes[8] = '{16'h4000, 16'hC000, 16'h7FFF, 16'h8000,
                                  16'h0001, 16'hFFFF, 16'h2000, 16'h0000};
        write_final_time(32'hFFFF_FFFF);
        // zero quaternion, unit quaternions, extreme lanes, extreme rates
        in = '0;
        send_sample(in);
        for (int i = 0; i < 8; i++) begin
            in.raw = '0;
            in.raw[16*(i%4) +: 16] = lanes[i];
            in.dx = 24'sh7FFFFF; in.dy = 24'sh800000; in.dz = 24'sh010000;
            in.dw = 24'sh800000;
            in.ax = 24'sh800000; in.ay = 24'sh7FFFFF; in.az = -24'sh010000;
            in.aw = 24'sh7FFFFF;
            in.now = i[0] ? 32'hFFFF_FFFF : 32'h0;
            send_sample(in);
        end
        in.raw = {4{16'h7FFF}}; send_sample(in);
        in.raw = {4{16'h8000}}; send_sample(in);
        in.raw = {16'h2000, 16'h2000, 16'h2000, 16'h2000};
        in.dx = 24'sh000001; in.dy = -24'sh000001; in.dz = 24'sh000003; in.dw = 24'sh000000;
        send_sample(in);
        wait_drained();
        // end-time boundary: equal, one past, one before, far past
        write_final_time(32'h0001_0000);
        in.now = 32'h0001_0000; send_sample(in);
        in.now = 32'h0001_0001; send_sample(in);
        in.now = 32'h0000_FFFF; send_sample(in);
        in.now = 32'hFFFF_FFFF; send_sample(in);
        wait_drained();
        // reset-like zero end time
        write_final_time(32'h0);
        in.now = 32'h0; send_sample(in);
        in.now = 32'h1; send_sample(in);
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [31:0] settings[4] = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h0123_4567};
        for (int phase = 0; phase < 4; phase++) begin
            write_final_time(phase == 3 ? $urandom : settings[phase]);
            for (int i = 0; i < count / 4; i++) send_sample(rand_sample(phase != 0));
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        write_final_time(32'hFFFF_FFFF);
        hold_off = 1'b1;
        for (int i = 0; i < 60; i++) send_sample(rand_sample(1'b0), 1'b1);
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(880);
        $display("covered %0d samples (%0d past the end time, %0d zero quaternions)",
                 sent, past_end_count, zero_quat_count);
        $display("checked %0d results across several end-time settings", received);
        if (errors == 0 && expected_rates.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
